@@ rtl/cdu_pkg.sv @@
package cdu_pkg;

   // calendar limits
   localparam logic [13:0] YEAR_MAX  = 14'd9999;
   localparam logic [3:0]  MONTH_JAN = 4'd1;
   localparam logic [3:0]  MONTH_FEB = 4'd2;
   localparam logic [3:0]  MONTH_MAR = 4'd3;
   localparam logic [3:0]  MONTH_DEC = 4'd12;
   // march-based month index of january is ten
   localparam logic [3:0]  MONTH_WRAP = 4'd9;

   // era split: y / 400 as (y * 5243) >> 21, exact for y below 10000
   localparam logic [13:0] YEARS_PER_ERA = 14'd400;
   localparam logic [12:0] ERA_RECIP     = 13'd5243;
   localparam int          ERA_SHIFT     = 21;
   localparam logic [8:0]  YOE_LAST      = 9'd399;

   localparam logic [18:0] DAYS_PER_YEAR = 19'd365;
   localparam logic [8:0]  CENT_1        = 9'd100;
   localparam logic [8:0]  CENT_2        = 9'd200;
   localparam logic [8:0]  CENT_3        = 9'd300;
   localparam logic [22:0] DAYS_PER_ERA  = 23'd146097;
   localparam logic [22:0] EPOCH_SHIFT   = 23'd719468;

   localparam logic [38:0] SECS_PER_DAY  = 39'd86400;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [16:0] SECS_PER_MIN  = 17'd60;

   // per-stage load enables
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

   // year split into era and year of era, plus day of year and time of day
   typedef struct packed {
      logic [5:0]  era;
      logic [8:0]  yoe;
      logic [9:0]  doy;
      logic [16:0] tod;
   } era_word_type;

   // day count and time of day
   typedef struct packed {
      logic [22:0] days;
      logic [16:0] tod;
   } day_word_type;

   // first day of each march-based month within the shifted year
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] res;
      case (mp)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd61;
         4'd3:    res = 9'd92;
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd184;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd245;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd337;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

@@ rtl/cdu_era_split.sv @@
module cdu_era_split (
   input  logic                 clock,
   input  cdu_pkg::stage_en_type en,
   input  logic [13:0]          year,
   input  logic [3:0]           month,
   input  logic [4:0]           day,
   input  logic [4:0]           hour,
   input  logic [5:0]           minute,
   input  logic [5:0]           second,
   output cdu_pkg::era_word_type era_word
);
   import cdu_pkg::*;

   logic [13:0] year_c;
   logic [3:0]  month_c;
   logic        early;
   logic [3:0]  mp;
   logic [26:0] era_prod;

   logic        neg_in, neg_ff;
   logic [13:0] yv_in, yv_ff;
   logic [4:0]  q_in, q_ff;
   logic [9:0]  doy_in, doy_ff;
   logic [16:0] tod_in, tod_ff;

   logic [13:0]  yoe_full;
   era_word_type era_in, era_ff;

   // stage 1: clamp, shift year to march, era quotient, day of year, time of day
   always_comb begin
      year_c  = (year > YEAR_MAX) ? YEAR_MAX : year;
      if (month < MONTH_JAN) begin
         month_c = MONTH_JAN;
      end else if (month > MONTH_DEC) begin
         month_c = MONTH_DEC;
      end else begin
         month_c = month;
      end
      early    = (month_c <= MONTH_FEB);
      neg_in   = early && (year_c == 14'd0);
      yv_in    = year_c - {13'd0, early};
      mp       = early ? (month_c + MONTH_WRAP) : (month_c - MONTH_MAR);
      era_prod = 27'(yv_in) * 27'(ERA_RECIP);
      q_in     = era_prod[ERA_SHIFT +: 5];
      doy_in   = 10'(month_start(mp)) + 10'(day) - 10'd1;
      tod_in   = 17'(hour) * SECS_PER_HOUR + 17'(minute) * SECS_PER_MIN + 17'(second);
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         neg_ff <= neg_in;
         yv_ff  <= yv_in;
         q_ff   <= q_in;
         doy_ff <= doy_in;
         tod_ff <= tod_in;
      end
   end

   // stage 2: year of era; shifted year minus one falls in era minus one
   always_comb begin
      yoe_full = yv_ff - 14'(q_ff) * YEARS_PER_ERA;
      if (neg_ff) begin
         era_in.era = 6'h3F;
         era_in.yoe = YOE_LAST;
      end else begin
         era_in.era = {1'b0, q_ff};
         era_in.yoe = yoe_full[8:0];
      end
      era_in.doy = doy_ff;
      era_in.tod = tod_ff;
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         era_ff <= era_in;
      end
   end

   assign era_word = era_ff;

endmodule

@@ rtl/cdu_day_count.sv @@
module cdu_day_count (
   input  logic                  clock,
   input  cdu_pkg::stage_en_type en,
   input  cdu_pkg::era_word_type era_word,
   output cdu_pkg::day_word_type day_word
);
   import cdu_pkg::*;

   logic [1:0]  cent;
   logic [18:0] doe_in, doe_ff;
   logic [22:0] era_days_in, era_days_ff;
   logic [16:0] tod_ff;

   day_word_type day_in, day_ff;

   // stage 3: day of era and era base, in two's complement
   always_comb begin
      if (era_word.yoe >= CENT_3) begin
         cent = 2'd3;
      end else if (era_word.yoe >= CENT_2) begin
         cent = 2'd2;
      end else if (era_word.yoe >= CENT_1) begin
         cent = 2'd1;
      end else begin
         cent = 2'd0;
      end
      doe_in = 19'(era_word.yoe) * DAYS_PER_YEAR + 19'(era_word.yoe[8:2]) - 19'(cent)
             + {{9{era_word.doy[9]}}, era_word.doy};
      era_days_in = {{17{era_word.era[5]}}, era_word.era} * DAYS_PER_ERA;
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         doe_ff      <= doe_in;
         era_days_ff <= era_days_in;
         tod_ff      <= era_word.tod;
      end
   end

   // stage 4: move origin to 1970-01-01
   always_comb begin
      day_in.days = era_days_ff + {{4{doe_ff[18]}}, doe_ff} - EPOCH_SHIFT;
      day_in.tod  = tod_ff;
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         day_ff <= day_in;
      end
   end

   assign day_word = day_ff;

endmodule

@@ rtl/cdu_sec_scale.sv @@
module cdu_sec_scale (
   input  logic                  clock,
   input  cdu_pkg::stage_en_type en,
   input  cdu_pkg::day_word_type day_word,
   output logic [22:0]           days,
   output logic [38:0]           secs
);
   import cdu_pkg::*;

   logic [22:0] days_ff;
   logic [38:0] secs_in, secs_ff;

   // stage 5: seconds from day count plus time of day
   always_comb begin
      secs_in = {{16{day_word.days[22]}}, day_word.days} * SECS_PER_DAY
              + 39'(day_word.tod);
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         days_ff <= day_word.days;
         secs_ff <= secs_in;
      end
   end

   assign days = days_ff;
   assign secs = secs_ff;

endmodule

@@ rtl/civil_date_to_unix_seconds.sv @@
// Calendar timestamp to Unix time converter.
// Input channel req_*: one word holds year, month, day, hour, minute, second.
// Result channel rsp_*: one word per input, in order, with the signed day
// count since 1970-01-01 and the signed Unix seconds.
// Both channels use valid/ready; a word moves when both are high.
// Each word passes through five register stages from input accept to
// rsp_valid (clamp and era quotient, year of era, day of era and era
// base, epoch offset, seconds multiply).
// Throughput: one word per cycle; each stage takes a new word whenever it
// is empty or its successor moves, so bubbles close up under stall.
// When the receiver holds rsp_ready low, the result stays on the outputs
// and the stages behind it keep filling; req_ready drops only once all
// five stages hold words.
// Reset clears all stage valid bits; no words are in flight afterwards.
// Out-of-range years saturate at 9999, months clamp to 1..12, and day,
// hour, minute and second add linearly without checks.
module civil_date_to_unix_seconds (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [13:0]        req_year,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day,
   input  logic [4:0]         req_hour,
   input  logic [5:0]         req_minute,
   input  logic [5:0]         req_second,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [22:0] rsp_days_since_epoch,
   output logic signed [38:0] rsp_unix_seconds
);
   import cdu_pkg::*;

   logic [4:0]   valid_ff, valid_in;
   stage_en_type en;
   era_word_type era_word;
   day_word_type day_word;
   logic [22:0]  days;
   logic [38:0]  secs;

   // stage load enables: a stage loads when empty or when its word moves on
   always_comb begin
      en.s5 = !valid_ff[4] || rsp_ready;
      en.s4 = !valid_ff[3] || en.s5;
      en.s3 = !valid_ff[2] || en.s4;
      en.s2 = !valid_ff[1] || en.s3;
      en.s1 = !valid_ff[0] || en.s2;
   end

   // valid bits travel with the data
   always_comb begin
      valid_in[0] = en.s1 ? req_valid   : valid_ff[0];
      valid_in[1] = en.s2 ? valid_ff[0] : valid_ff[1];
      valid_in[2] = en.s3 ? valid_ff[1] : valid_ff[2];
      valid_in[3] = en.s4 ? valid_ff[2] : valid_ff[3];
      valid_in[4] = en.s5 ? valid_ff[3] : valid_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   cdu_era_split u_era_split (
      .clock    (clock),
      .en       (en),
      .year     (req_year),
      .month    (req_month),
      .day      (req_day),
      .hour     (req_hour),
      .minute   (req_minute),
      .second   (req_second),
      .era_word (era_word)
   );

   cdu_day_count u_day_count (
      .clock    (clock),
      .en       (en),
      .era_word (era_word),
      .day_word (day_word)
   );

   cdu_sec_scale u_sec_scale (
      .clock    (clock),
      .en       (en),
      .day_word (day_word),
      .days     (days),
      .secs     (secs)
   );

   assign req_ready            = en.s1;
   assign rsp_valid            = valid_ff[4];
   assign rsp_days_since_epoch = $signed(days);
   assign rsp_unix_seconds     = $signed(secs);

endmodule
